### sv/ima_adpcm_block_decoder_top_assert.svh
// ============================================================================
// IMA ADPCM block decoder - assertion macros
// Concurrent assertion helpers on aclk, with and without reset gating.
// Both are empty when SYNTH is defined.
// ============================================================================
`ifndef IMA_ADPCM_BLOCK_DECODER_TOP_ASSERT_SVH
`define IMA_ADPCM_BLOCK_DECODER_TOP_ASSERT_SVH

`ifndef SYNTH
// property checked every edge of aclk, ignored while aresetn is low
`define IMA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
// property checked every edge of aclk, reset included
`define IMA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);
`else
`define IMA_ASSERT(label, prop, msg)
`define IMA_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

### sv/ima_dec_pkg.sv
// ============================================================================
// IMA ADPCM block decoder - package
// Widths, header positions, step table and decoder state type.
// ============================================================================
`default_nettype none

package ima_dec_pkg;

    // block geometry
    localparam int MaxBlockBytes = 4096;
    localparam int MinBlockBytes = 8;
    localparam int PosW          = $clog2(MaxBlockBytes);
    localparam int SizeW         = PosW + 1;
    localparam int CfgW          = 13;

    // payload widths
    localparam int SampleW = 16;
    localparam int ByteW   = 8;
    localparam int NibW    = 4;
    localparam int IdxW    = 7;
    localparam int StepW   = 15;

    localparam logic [IdxW-1:0] IdxMax = 7'd88;
    localparam logic [CfgW-1:0] BlockBytesRst = 13'd1024;

    // byte positions inside the block header
    localparam logic [PosW-1:0] PosHdrLo  = PosW'(0);
    localparam logic [PosW-1:0] PosHdrHi  = PosW'(1);
    localparam logic [PosW-1:0] PosHdrIdx = PosW'(2);
    localparam logic [PosW-1:0] PosHdrRsv = PosW'(3);

    // running decoder state
    typedef struct packed {
        logic [SampleW-1:0] pred;
        logic [IdxW-1:0]    idx;
    } dec_state_t;

    // standard IMA step sizes
    localparam logic [StepW-1:0] StepTab [0:88] = '{
        15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14,
        15'd16, 15'd17, 15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31,
        15'd34, 15'd37, 15'd41, 15'd45, 15'd50, 15'd55, 15'd60, 15'd66,
        15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118, 15'd130, 15'd143,
        15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279, 15'd307,
        15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
        15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282,
        15'd1411, 15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499,
        15'd2749, 15'd3024, 15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871,
        15'd5358, 15'd5894, 15'd6484, 15'd7132, 15'd7845, 15'd8630, 15'd9493,
        15'd10442, 15'd11487, 15'd12635, 15'd13899, 15'd15289, 15'd16818,
        15'd18500, 15'd20350, 15'd22385, 15'd24623, 15'd27086, 15'd29794,
        15'd32767
    };

    // clamp an index to the top of the table
    function automatic logic [IdxW-1:0] idx_clamp(input logic [IdxW-1:0] idx);
        return (idx > IdxMax) ? IdxMax : idx;
    endfunction

    // step size for an index, out-of-range index reads the top entry
    function automatic logic [StepW-1:0] step_of(input logic [IdxW-1:0] idx);
        return StepTab[idx_clamp(idx)];
    endfunction

endpackage

`default_nettype wire

### sv/ima_dec_nibble.sv
// ============================================================================
// IMA ADPCM block decoder - nibble decode
// One 4-bit code applied to the predictor and step index: scaled step add,
// int16 saturation, index adjust clamped to 0..88.
// ============================================================================
`default_nettype none

module ima_dec_nibble
    import ima_dec_pkg::*;
(
    input  dec_state_t        state_cur,
    input  logic [NibW-1:0]   nib,
    output dec_state_t        state_new
);

    logic [StepW-1:0]   step;
    logic [SampleW-1:0] diff;
    logic [SampleW+1:0] sum;
    logic [IdxW-1:0]    idx_c;
    logic [7:0]         adj;
    logic [7:0]         idx_sum;

    // difference from the step, magnitude bits then sign
    always_comb begin
        idx_c = idx_clamp(state_cur.idx);
        step  = step_of(idx_c);
        diff  = {4'b0, step[StepW-1:3]};
        if (nib[0]) begin
            diff = diff + {3'b0, step[StepW-1:2]};
        end
        if (nib[1]) begin
            diff = diff + {2'b0, step[StepW-1:1]};
        end
        if (nib[2]) begin
            diff = diff + {1'b0, step};
        end
        sum = {{2{state_cur.pred[SampleW-1]}}, state_cur.pred}
            + (nib[3] ? (18'd0 - {2'b0, diff}) : {2'b0, diff});
    end

    always_comb begin
        // saturate to int16
        if ($signed(sum) > 18'sd32767) begin
            state_new.pred = 16'h7FFF;
        end else if ($signed(sum) < -18'sd32768) begin
            state_new.pred = 16'h8000;
        end else begin
            state_new.pred = sum[SampleW-1:0];
        end

        // index step: -1 for small codes, 2/4/6/8 for large ones
        adj     = nib[2] ? 8'(({6'b0, nib[1:0]} + 8'd1) << 1) : 8'hFF;
        idx_sum = {1'b0, idx_c} + adj;
        if (idx_sum[7]) begin
            state_new.idx = '0;
        end else if (idx_sum[IdxW-1:0] > IdxMax) begin
            state_new.idx = IdxMax;
        end else begin
            state_new.idx = idx_sum[IdxW-1:0];
        end
    end

endmodule

`default_nettype wire

### sv/ima_adpcm_block_decoder_top.sv
// ============================================================================
// IMA ADPCM block decoder - top level
// Splits a byte stream into blocks, loads the four-byte header and decodes
// each later byte into two PCM samples, low nibble first.
// ============================================================================
//
//  channel   dir  tdata                tuser          tlast
//  s_*       in   [7:0] data_byte      -              end_of_stream
//  m_*       out  [15:0] sample        block_start    run_last
//  cfg_*     in   [12:0] block_bytes   (write strobe cfg_wr_en, no read-back)
//
//  Header bytes 0..2 give no output beat; header byte 3 gives one output
//  beat. A data byte goes through the single nibble decoder one nibble at
//  a time, low then high; no new byte is taken until the high one is done.
//  Bytes register in the input stage, samples in the output register.
//  Reset clears the control registers; no memory, no clearing pass.
//  A stall on m_tready holds the decode stage, which then back-pressures
//  s_tready; the input stage refills in the cycle its byte completes.
//
`default_nettype none
`include "ima_adpcm_block_decoder_top_assert.svh"

module ima_adpcm_block_decoder_top
    import ima_dec_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // config
    input  logic                cfg_wr_en,
    input  logic [CfgW-1:0]     cfg_wr_data,     // block_bytes
    // input stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [ByteW-1:0]    s_tdata,         // [7:0] data_byte
    input  logic                s_tlast,         // end_of_stream
    // output stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [SampleW-1:0]  m_tdata,         // [15:0] sample
    output logic                m_tuser,         // block_start
    output logic                m_tlast          // run_last
);

    // registers
    logic [CfgW-1:0]    block_bytes_reg, block_bytes_next;
    logic               in_vld_reg, in_vld_next;
    logic [ByteW-1:0]   in_byte_reg, in_byte_next;
    logic               in_eos_reg, in_eos_next;
    logic               nib_hi_reg, nib_hi_next;
    logic [PosW-1:0]    pos_reg, pos_next;
    logic [ByteW-1:0]   hdr_lo_reg, hdr_lo_next;
    dec_state_t         dec_reg, dec_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [SampleW-1:0] m_tdata_reg, m_tdata_next;
    logic               m_tuser_reg, m_tuser_next;
    logic               m_tlast_reg, m_tlast_next;

    // combinational
    logic [SizeW-1:0]   size_eff;
    logic [SizeW-1:0]   pos_inc;
    logic               blk_end;
    logic               is_data;
    logic               need_out;
    logic               out_free;
    logic               fire;
    logic               done;
    logic               in_take;
    logic [NibW-1:0]    nib;
    dec_state_t         dec_nib;

    // effective block size, clamped to the supported range
    always_comb begin
        if (block_bytes_reg < CfgW'(MinBlockBytes)) begin
            size_eff = SizeW'(MinBlockBytes);
        end else if (32'(block_bytes_reg) > MaxBlockBytes) begin
            size_eff = SizeW'(MaxBlockBytes);
        end else begin
            size_eff = SizeW'(block_bytes_reg);
        end
    end

    assign pos_inc = {1'b0, pos_reg} + SizeW'(1);
    assign blk_end = in_eos_reg || (pos_inc >= size_eff);

    // nibble decoder shared by both halves of a data byte
    assign nib = nib_hi_reg ? in_byte_reg[7:4] : in_byte_reg[3:0];

    ima_dec_nibble u_nibble (
        .state_cur (dec_reg),
        .nib       (nib),
        .state_new (dec_nib)
    );

    // stage control
    assign is_data  = pos_reg > PosHdrRsv;
    assign need_out = in_vld_reg && (pos_reg >= PosHdrRsv);
    assign out_free = !m_tvalid_reg || m_tready;
    assign fire     = in_vld_reg && (!need_out || out_free);
    assign done     = fire && (!is_data || nib_hi_reg);
    assign s_tready = !in_vld_reg || done;
    assign in_take  = s_tvalid && s_tready;

    // next-state logic
    always_comb begin
        block_bytes_next = cfg_wr_en ? cfg_wr_data : block_bytes_reg;

        in_vld_next  = in_vld_reg;
        in_byte_next = in_byte_reg;
        in_eos_next  = in_eos_reg;
        if (in_take) begin
            in_vld_next  = 1'b1;
            in_byte_next = s_tdata;
            in_eos_next  = s_tlast;
        end else if (done) begin
            in_vld_next = 1'b0;
        end

        nib_hi_next = nib_hi_reg;
        if (done) begin
            nib_hi_next = 1'b0;
        end else if (fire && is_data) begin
            nib_hi_next = 1'b1;
        end

        pos_next = pos_reg;
        if (done) begin
            pos_next = blk_end ? '0 : pos_inc[PosW-1:0];
        end

        // header load and nibble update
        hdr_lo_next = hdr_lo_reg;
        dec_next    = dec_reg;
        if (fire) begin
            if (pos_reg == PosHdrLo) begin
                hdr_lo_next = in_byte_reg;
            end else if (pos_reg == PosHdrHi) begin
                dec_next.pred = {in_byte_reg, hdr_lo_reg};
            end else if (pos_reg == PosHdrIdx) begin
                dec_next.idx = (in_byte_reg > ByteW'(IdxMax)) ? IdxMax
                                                              : in_byte_reg[IdxW-1:0];
            end else if (is_data) begin
                dec_next = dec_nib;
            end
        end

        // output register
        m_tvalid_next = m_tready ? 1'b0 : m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        if (fire && need_out) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = is_data ? dec_nib.pred : dec_reg.pred;
            m_tuser_next  = !is_data;
            m_tlast_next  = !is_data || nib_hi_reg;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_bytes_reg <= BlockBytesRst;
            in_vld_reg      <= 1'b0;
            nib_hi_reg      <= 1'b0;
            pos_reg         <= '0;
            hdr_lo_reg      <= '0;
            dec_reg         <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            block_bytes_reg <= block_bytes_next;
            in_vld_reg      <= in_vld_next;
            nib_hi_reg      <= nib_hi_next;
            pos_reg         <= pos_next;
            hdr_lo_reg      <= hdr_lo_next;
            dec_reg         <= dec_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        in_byte_reg <= in_byte_next;
        in_eos_reg  <= in_eos_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // checks
    `IMA_ASSERT(a_idx_range, dec_reg.idx <= IdxMax, "step index above 88")
    `IMA_ASSERT(a_hi_needs_byte, nib_hi_reg |-> in_vld_reg, "high nibble with empty stage")
    `IMA_ASSERT(a_hdr_is_last, (m_tvalid_reg && m_tuser_reg) |-> m_tlast_reg,
                "header sample not marked last")
    `IMA_ASSERT(a_hi_follows_lo, (fire && is_data && !nib_hi_reg) |=> (in_vld_reg && nib_hi_reg),
                "low nibble not followed by high nibble")
    `IMA_ASSERT_ALWAYS(a_pos_reset, !aresetn |=> (pos_reg == PosHdrLo && !nib_hi_reg),
                "position not cleared by reset")

endmodule

`default_nettype wire
